@@ src/clns_pkg.sv @@
// Shared types and constants for the character LCD nibble sequencer.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package clns_pkg;

  // Request kinds
  localparam logic [2:0] CMD_BYTE   = 3'd0;
  localparam logic [2:0] CMD_DATA   = 3'd1;
  localparam logic [2:0] CMD_INIT   = 3'd2;
  localparam logic [2:0] CMD_CURSOR = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // Configuration register file
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int REG_W     = 16;

  localparam logic [REG_IDX_W-1:0] REG_ENABLE_HIGH = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CMD_WAIT    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DATA_WAIT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_POWER_UP    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_WAKE  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_WAKE_WAIT   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CLEAR_EXTRA = 3'd7;

  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    16'd5, 16'd100, 16'd2000, 16'd100, 16'd50000, 16'd5000, 16'd150, 16'd2000
  };

  // Strobe sequencing
  localparam int                STEP_W          = 4;
  localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 4'd1;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 4'd11;
  localparam logic [STEP_W-1:0] WAKE_LAST_STEP  = 4'd3;
  localparam logic [STEP_W-1:0] INIT_FIRST_BYTE = 4'd4;

  // LCD constants
  localparam logic [3:0] NIB_WAKE        = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT    = 4'h2;
  localparam logic [7:0] LCD_FUNC_SET    = 8'h28;
  localparam logic [7:0] LCD_DISP_ON     = 8'h0C;
  localparam logic [7:0] LCD_CLR_DISPLAY = 8'h01;
  localparam logic [7:0] LCD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0] LCD_SET_DDRAM   = 8'h80;
  localparam logic [1:0] INIT_CLEAR_IDX  = 2'd2;

  // Command byte sent after the wake-up nibbles, by position
  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = LCD_FUNC_SET;
      2'd1:    b = LCD_DISP_ON;
      2'd2:    b = LCD_CLR_DISPLAY;
      default: b = LCD_ENTRY_MODE;
    endcase
    return b;
  endfunction

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;
    logic              emit;
    logic [STEP_W-1:0] step;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_ok;
    logic last_step;
    logic out_free;
  } dp_stat_t;

endpackage

@@ src/char_lcd_nibble_sequencer_top.sv @@
// A request is latched and the controller enters its run state; the first
// strobe is registered once the output register is free. One strobe per
// cycle while out_stall is low; the step counter in the controller gives
// two strobes for byte, data, cursor and clear, twelve for init. Unknown
// kinds are accepted and give no strobes. Reset (rst_n, synchronous, active
// low) returns to idle, empties the output register and loads the default timing registers.
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [clns_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [clns_pkg::REG_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       in_cmd,
  input  logic [7:0]                       in_byte_value,
  input  logic                             in_row,
  input  logic [5:0]                       in_col,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_rs,
  output logic [3:0]                       out_nibble,
  output logic [15:0]                      out_enable_us,
  output logic [15:0]                      out_wait_before_us,
  output logic [15:0]                      out_wait_after_us,
  output logic                             out_last
);
  import clns_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Controller
  clns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  clns_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_cmd             (in_cmd),
    .in_byte_value      (in_byte_value),
    .in_row             (in_row),
    .in_col             (in_col),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_rs             (out_rs),
    .out_nibble         (out_nibble),
    .out_enable_us      (out_enable_us),
    .out_wait_before_us (out_wait_before_us),
    .out_wait_after_us  (out_wait_after_us),
    .out_last           (out_last)
  );

endmodule

@@ src/clns_ctrl.sv @@
// Sequencer controller: request intake and strobe step counter.
// Depends on clns_pkg.
`timescale 1ns / 1ps

module clns_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  clns_pkg::dp_stat_t   stat,
  output clns_pkg::ctrl_cmd_t  cmd
);
  import clns_pkg::*;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  // State and step registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_valid && stat.req_ok) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (stat.out_free) begin
          step_nxt = step_r + STEP_W'(1);
          if (stat.last_step) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.step = step_r;
    cmd.load = 1'b0;
    cmd.emit = 1'b0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.emit = stat.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Step counter stays inside the longest sequence
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> step_r <= INIT_LAST_STEP)
    else $error("step counter beyond last init strobe");

  // Final strobe returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && stat.last_step) |=> state_r == ST_IDLE)
    else $error("controller did not return to idle after final strobe");

  // A new run always starts at the first strobe
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && stat.req_ok) |=> (state_r == ST_RUN && step_r == '0))
    else $error("run did not start at step zero");

endmodule

@@ src/clns_dp.sv @@
// Sequencer datapath: configuration registers, request latch, strobe
// formation and output register. Depends on clns_pkg.
`timescale 1ns / 1ps

module clns_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [clns_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [clns_pkg::REG_W-1:0]       cfg_wdata,
  input  logic [2:0]                       in_cmd,
  input  logic [7:0]                       in_byte_value,
  input  logic                             in_row,
  input  logic [5:0]                       in_col,
  input  clns_pkg::ctrl_cmd_t              cmd,
  output clns_pkg::dp_stat_t               stat,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_rs,
  output logic [3:0]                       out_nibble,
  output logic [15:0]                      out_enable_us,
  output logic [15:0]                      out_wait_before_us,
  output logic [15:0]                      out_wait_after_us,
  output logic                             out_last
);
  import clns_pkg::*;

  logic [REG_W-1:0] cfg_r [NUM_REGS];

  logic [2:0]  kind_r;
  logic [7:0]  byte_r;
  logic [7:0]  byte_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_rs_r, out_last_r;
  logic [3:0]  out_nibble_r;
  logic [15:0] out_enable_r, out_before_r, out_after_r;

  logic              is_init, is_wake, hi_phase, add_clr, last_step;
  logic [STEP_W-1:0] step;
  logic [2:0]        bidx_full;
  logic [1:0]        bidx;
  logic [7:0]        cur_byte;
  logic [3:0]        nibble;
  logic [15:0]       extra, wait_pre;
  logic [17:0]       wait_sum;
  logic [15:0]       wait_after;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_r[i] <= REG_RESET[i];
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  // Byte to send for single-byte requests
  always_comb begin
    unique case (in_cmd)
      CMD_CURSOR: byte_nxt = LCD_SET_DDRAM | {1'b0, in_row, in_col};
      CMD_CLEAR:  byte_nxt = LCD_CLR_DISPLAY;
      default:    byte_nxt = in_byte_value;
    endcase
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= CMD_BYTE;
    end else if (cmd.load) begin
      kind_r <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) byte_r <= byte_nxt;
  end

  // Strobe formation for the current step
  always_comb begin
    step      = cmd.step;
    is_init   = (kind_r == CMD_INIT);
    is_wake   = is_init && (step <= WAKE_LAST_STEP);
    hi_phase  = ~step[0];
    bidx_full = step[3:1] - 3'd2;
    bidx      = bidx_full[1:0];
    cur_byte  = is_init ? init_byte(bidx) : byte_r;

    if (is_wake) nibble = (step == WAKE_LAST_STEP) ? NIB_FOUR_BIT : NIB_WAKE;
    else         nibble = hi_phase ? cur_byte[7:4] : cur_byte[3:0];

    wait_pre = (is_init && step == '0) ? cfg_r[REG_POWER_UP] : '0;

    add_clr = 1'b0;
    priority if (is_wake) begin
      extra = (step == '0) ? cfg_r[REG_FIRST_WAKE] : cfg_r[REG_WAKE_WAIT];
    end else if (hi_phase) begin
      extra = '0;
    end else begin
      extra   = (kind_r == CMD_DATA) ? cfg_r[REG_DATA_WAIT] : cfg_r[REG_CMD_WAIT];
      add_clr = (kind_r == CMD_CLEAR) || (is_init && bidx == INIT_CLEAR_IDX);
    end

    wait_sum = {2'b00, cfg_r[REG_SETTLE]} + {2'b00, extra}
             + (add_clr ? {2'b00, cfg_r[REG_CLEAR_EXTRA]} : 18'd0);
    wait_after = (|wait_sum[17:16]) ? 16'hFFFF : wait_sum[15:0];

    last_step = is_init ? (step == INIT_LAST_STEP) : (step == BYTE_LAST_STEP);
  end

  // Output register
  always_comb begin
    if (cmd.emit)      out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else               out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rs_r     <= (kind_r == CMD_DATA);
      out_nibble_r <= nibble;
      out_enable_r <= cfg_r[REG_ENABLE_HIGH];
      out_before_r <= wait_pre;
      out_after_r  <= wait_after;
      out_last_r   <= last_step;
    end
  end

  // Status to controller
  always_comb begin
    stat.req_ok    = (in_cmd <= CMD_CLEAR);
    stat.last_step = last_step;
    stat.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid          = out_valid_r;
  assign out_rs             = out_rs_r;
  assign out_nibble         = out_nibble_r;
  assign out_enable_us      = out_enable_r;
  assign out_wait_before_us = out_before_r;
  assign out_wait_after_us  = out_after_r;
  assign out_last           = out_last_r;

  // A strobe never overwrites one still waiting to be taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("strobe written over a stalled result");

  // Load and emit never happen together
  a_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.emit))
    else $error("request load during strobe emission");

endmodule
